[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the RTL file flc_sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond in one cycle implies prop in the next.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[hdl/flc_pkg.sv]
// ----------------------------------------------------------------------------
// flc_pkg
// Types, constants and lamp patterns of the five-light traffic controller.
// ----------------------------------------------------------------------------
package flc_pkg;

   localparam int unsigned TIME_W    = 16;
   localparam int unsigned ELAPSED_W = 17;
   localparam int unsigned LAMPS_W   = 15;
   localparam int unsigned PHASE_W   = 3;
   localparam int unsigned PADDR_W   = 4;
   localparam int unsigned PDATA_W   = 32;

   localparam logic [TIME_W-1:0] GREEN_RESET  = 16'd10000;
   localparam logic [TIME_W-1:0] YELLOW_RESET = 16'd2000;
   localparam logic [TIME_W-1:0] FLASH_RESET  = 16'd500;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

   localparam logic [PHASE_W-1:0] PHASE_CLEAR     = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_FIRST     = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_LAST      = 3'd6;
   localparam logic [PHASE_W-1:0] PHASE_CROSSING  = 3'd7;

   localparam logic [LAMPS_W-1:0] ALL_YELLOW = 15'h2492;
   localparam logic [LAMPS_W-1:0] L1_YELLOW  = 15'h0002;

   typedef enum logic [1:0] {
      REG_GREEN  = 2'd0,
      REG_YELLOW = 2'd1,
      REG_FLASH  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] green_time;
      logic [TIME_W-1:0] yellow_time;
      logic [TIME_W-1:0] flash_time;
   } timing_type;

   typedef struct packed {
      logic tick;
      logic button_pressed;
      logic alert_toggle;
   } req_word_type;

   function automatic logic [LAMPS_W-1:0] phase_pattern(input logic [PHASE_W-1:0] phase);
      logic [LAMPS_W-1:0] bits;
      unique case (phase)
         3'd1:    bits = 15'h1264;
         3'd2:    bits = 15'h1262;
         3'd3:    bits = 15'h4321;
         3'd4:    bits = 15'h4291;
         3'd5:    bits = 15'h4849;
         3'd6:    bits = 15'h2449;
         3'd7:    bits = 15'h1261;
         default: bits = 15'h0000;
      endcase
      return bits;
   endfunction

endpackage

[hdl/five_light_traffic_controller_unit.sv]
// ----------------------------------------------------------------------------
// five_light_traffic_controller_unit
// Five-light traffic phase sequencer with pedestrian phase and alert flashing.
// ----------------------------------------------------------------------------
// One request word (tick, button, alert toggle) yields one result word (lamps,
// phase, alert flag). A word is held in the input register and then stepped
// into the result register; the unit takes one word every cycle while the
// result register is free or being read, and the result register and the input
// register let a new word enter while a result waits. Durations are set over
// the register port (0x0 green, 0x4 yellow, 0x8 flash) and take effect at the
// next phase reload.
module five_light_traffic_controller_unit import flc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_tick,
   input  logic               req_button_pressed,
   input  logic               req_alert_toggle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LAMPS_W-1:0] rsp_lamps,
   output logic [PHASE_W-1:0] rsp_phase,
   output logic               rsp_alert_active,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready
);

   timing_type   timing;
   logic         word_valid;
   req_word_type word;
   logic         word_take;

   flc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timing      (timing)
   );

   flc_req_stage u_req_stage (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_tick           (req_tick),
      .req_button_pressed (req_button_pressed),
      .req_alert_toggle   (req_alert_toggle),
      .word_valid         (word_valid),
      .word               (word),
      .word_take          (word_take)
   );

   flc_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .timing           (timing),
      .word_valid       (word_valid),
      .word             (word),
      .word_take        (word_take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lamps        (rsp_lamps),
      .rsp_phase        (rsp_phase),
      .rsp_alert_active (rsp_alert_active)
   );

endmodule

[hdl/flc_csr.sv]
// ----------------------------------------------------------------------------
// flc_csr
// APB-style register file for the green, yellow and flash durations.
// ----------------------------------------------------------------------------
module flc_csr import flc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready,
   output timing_type         timing
);

   timing_type    timing_ff;
   timing_type    timing_in;
   reg_index_type index;
   logic          write_en;
   logic [TIME_W-1:0] value;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[PADDR_W-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign value      = csr_pwdata[TIME_W-1:0];
   assign timing     = timing_ff;

   always_comb begin
      timing_in = timing_ff;
      if (write_en) begin
         unique case (index)
            REG_GREEN:  timing_in.green_time  = value;
            REG_YELLOW: timing_in.yellow_time = value;
            REG_FLASH:  timing_in.flash_time  = value;
            default:    timing_in = timing_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_GREEN:  csr_prdata = {{(PDATA_W-TIME_W){1'b0}}, timing_ff.green_time};
         REG_YELLOW: csr_prdata = {{(PDATA_W-TIME_W){1'b0}}, timing_ff.yellow_time};
         REG_FLASH:  csr_prdata = {{(PDATA_W-TIME_W){1'b0}}, timing_ff.flash_time};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.green_time  <= GREEN_RESET;
         timing_ff.yellow_time <= YELLOW_RESET;
         timing_ff.flash_time  <= FLASH_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

endmodule

[hdl/flc_req_stage.sv]
// ----------------------------------------------------------------------------
// flc_req_stage
// Input register: captures one request word and holds it until taken.
// ----------------------------------------------------------------------------
module flc_req_stage import flc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_tick,
   input  logic         req_button_pressed,
   input  logic         req_alert_toggle,
   output logic         word_valid,
   output req_word_type word,
   input  logic         word_take
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         load;

   assign req_ready  = ~valid_ff | word_take;
   assign load       = req_valid & req_ready;
   assign valid_in   = load | (valid_ff & ~word_take);
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff.tick           <= req_tick;
         word_ff.button_pressed <= req_button_pressed;
         word_ff.alert_toggle   <= req_alert_toggle;
      end
   end

endmodule

[hdl/flc_sequencer.sv]
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// flc_sequencer
// Phase timer, lamp pattern select and result register; one word per cycle while rsp_ready allows.
// ----------------------------------------------------------------------------
module flc_sequencer import flc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  timing_type         timing,
   input  logic               word_valid,
   input  req_word_type       word,
   output logic               word_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LAMPS_W-1:0] rsp_lamps,
   output logic [PHASE_W-1:0] rsp_phase,
   output logic               rsp_alert_active
);

   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [TIME_W-1:0]    held_ff, held_in;
   logic                 alert_ff, alert_in;
   logic                 crossing_ff, crossing_in;
   logic [LAMPS_W-1:0]   lamps_ff, lamps_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [PHASE_W-1:0]   phase_a;
   logic [PHASE_W-1:0]   limit;
   logic [ELAPSED_W-1:0] elapsed_t;
   logic                 expire;

   assign word_take    = word_valid & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid_in = word_take | (rsp_valid_ff & ~rsp_ready);

   always_comb begin
      alert_in    = alert_ff ^ word.alert_toggle;
      phase_a     = (word.alert_toggle & alert_ff) ? PHASE_CLEAR : phase_ff;
      elapsed_t   = (word.tick && elapsed_ff != ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
      expire      = elapsed_t > {1'b0, held_ff};
      limit       = crossing_ff ? PHASE_CROSSING : PHASE_LAST;
      phase_in    = phase_a;
      elapsed_in  = elapsed_t;
      held_in     = held_ff;
      lamps_in    = lamps_ff;
      crossing_in = crossing_ff;
      if (expire) begin
         phase_in   = (phase_a < limit) ? phase_a + 1'b1 : PHASE_FIRST;
         elapsed_in = '0;
         if (alert_in) begin
            held_in  = timing.flash_time;
            lamps_in = ((lamps_ff & L1_YELLOW) != '0) ? '0 : ALL_YELLOW;
         end else if (phase_in != PHASE_CLEAR) begin
            lamps_in = phase_pattern(phase_in);
            if (phase_in == PHASE_CROSSING) begin
               held_in     = timing.green_time;
               crossing_in = 1'b0;
            end else if (phase_in[0]) begin
               held_in = timing.green_time;
            end else begin
               held_in = timing.yellow_time;
            end
         end
      end
      if (word.button_pressed) begin
         crossing_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_FIRST;
         elapsed_ff   <= '0;
         held_ff      <= GREEN_RESET;
         alert_ff     <= 1'b0;
         crossing_ff  <= 1'b0;
         lamps_ff     <= phase_pattern(PHASE_FIRST);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (word_take) begin
            phase_ff    <= phase_in;
            elapsed_ff  <= elapsed_in;
            held_ff     <= held_in;
            alert_ff    <= alert_in;
            crossing_ff <= crossing_in;
            lamps_ff    <= lamps_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lamps        = lamps_ff;
   assign rsp_phase        = phase_ff;
   assign rsp_alert_active = alert_ff;

   `ASSERT_CLK(a_elapsed_bound, clock, reset, elapsed_ff <= {1'b0, held_ff}, "elapsed past held duration")
   `ASSERT_CLK(a_crossing_clear, clock, reset, $fell(crossing_ff) |-> phase_ff == PHASE_CROSSING, "crossing request cleared outside crossing phase")
   `ASSERT_NEXT(a_hold_state, clock, reset, !word_take, $stable(phase_ff) && $stable(lamps_ff), "state moved without a word")

endmodule
